@@ rtl/core/gssb_pkg.sv @@
// Package for the grouped spatial scale-and-bias block: beat types, mode, status
// and register codes, sequencer states, rounding and divider-step functions.
// No dependencies.
`default_nettype none

package gssb_pkg;

    localparam int DATA_W      = 16;
    localparam int WGRAD_W     = 48;
    localparam int BGRAD_W     = 32;
    localparam int CH_COUNT_W  = 9;
    localparam int SHARE_W     = 9;
    localparam int PLANE_SZ_W  = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int DIV_W       = 9;
    localparam int DIV_CNT_W   = 4;

    localparam int MAX_GROUPS_DEF = 16;
    localparam int MAX_PLANE_DEF  = 1024;
    localparam int MAX_CHANNELS   = 256;

    localparam logic [2:0] MODE_LOAD_W = 3'd0;
    localparam logic [2:0] MODE_LOAD_B = 3'd1;
    localparam logic [2:0] MODE_FWD    = 3'd2;
    localparam logic [2:0] MODE_BWD    = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_RANGE  = 2'd1;
    localparam logic [1:0] STATUS_CONFIG = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHARE_GROUP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_SIZE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS_ENABLE   = 2'd3;

    typedef struct packed {
        logic [2:0]               mode;
        logic [7:0]               channel;
        logic [9:0]               position;
        logic signed [DATA_W-1:0] data_value;
        logic signed [DATA_W-1:0] top_grad;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  result_value;
        logic signed [WGRAD_W-1:0] weight_grad_out;
        logic signed [BGRAD_W-1:0] bias_grad_out;
        logic [1:0]                status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ADDR,
        ST_READ,
        ST_MULT,
        ST_WRITE,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_step_t;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic div_step_t div_step(input div_step_t cur,
                                           input logic [DIV_W-1:0] divisor);
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        div_step_t      nxt;
        trial = {cur.rem, cur.quot[DIV_W-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            nxt.rem  = diff[DIV_W-1:0];
            nxt.quot = {cur.quot[DIV_W-2:0], 1'b1};
        end else begin
            nxt.rem  = trial[DIV_W-1:0];
            nxt.quot = {cur.quot[DIV_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // Q8.24 to Q4.12: round half up, saturate.
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [33:0] p);
        logic signed [33:0] t;
        logic signed [21:0] s;
        t = p + 34'sd2048;
        s = t[33:12];
        if (s > 22'sd32767) begin
            return 16'sh7fff;
        end else if (s < -22'sd32768) begin
            return 16'sh8000;
        end else begin
            return s[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gssb_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module gssb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/grouped_spatial_scale_bias.sv @@
// Grouped spatial scale-and-bias: top level, sequencer and datapath.
// Depends on gssb_pkg and gssb_ram (weight/bias store, gradient store).
//
// One beat is worked at a time. A beat that touches the stores passes, from acceptance
// to the result register, through the bit-serial divider that forms the group index
// and checks the share configuration, then address, memory read, multiply and
// write-back; a beat rejected by status or with an unused mode skips memory read, multiply and write-back.
// The next beat may be accepted while a result waits on m_ready. After reset the
// gradient store is cleared one entry a cycle until all MAX_GROUPS*MAX_PLANE entries
// (16384 by default) are cleared; s_ready stays low meanwhile, configuration writes
// are taken as ever. Entry address = group*MAX_PLANE + position.
`default_nettype none

module grouped_spatial_scale_bias #(
    parameter int MAX_GROUPS = gssb_pkg::MAX_GROUPS_DEF,
    parameter int MAX_PLANE  = gssb_pkg::MAX_PLANE_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire gssb_pkg::in_item_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output gssb_pkg::out_item_t                      m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [gssb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [gssb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import gssb_pkg::*;

    localparam int STORE_DEPTH = MAX_GROUPS * MAX_PLANE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int WP_W        = 2 * DATA_W;
    localparam int GR_W        = WGRAD_W + BGRAD_W;

    // configuration
    logic [CH_COUNT_W-1:0] cfg_cc_reg;
    logic [SHARE_W-1:0]    cfg_sg_reg;
    logic [PLANE_SZ_W-1:0] cfg_ps_reg;
    logic                  cfg_be_reg;

    // control
    seq_state_t            state_reg, state_next;
    logic                  clr_active_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    in_item_t              item_reg;
    div_step_t             div_ch_reg, div_cc_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [1:0]            status_reg;
    logic signed [31:0]    prod_a_reg, prod_b_reg;
    logic signed [DATA_W-1:0]  res_value_reg;
    logic signed [WGRAD_W-1:0] wg_out_reg;
    logic signed [BGRAD_W-1:0] bg_out_reg;
    out_item_t             out_data_reg;

    logic                  s_accept;
    logic                  out_load;
    logic                  cfg_ok;
    logic                  in_range;
    logic                  mode_known;
    logic                  access_ok;
    logic [31:0]           addr_full;

    logic                  wp_we;
    logic [WP_W-1:0]       wp_wdata, wp_rdata;
    logic                  gr_we;
    logic [ADDR_W-1:0]     gr_waddr;
    logic [GR_W-1:0]       gr_wdata, gr_rdata;

    logic signed [DATA_W-1:0]  rd_w, rd_b;
    logic signed [WGRAD_W-1:0] rd_wg, wg_new;
    logic signed [BGRAD_W-1:0] rd_bg, bg_new;
    logic signed [DATA_W-1:0]  mul_op;
    logic signed [33:0]        fwd_sum, bwd_sum;
    logic [WGRAD_W:0]          wg_sum;
    logic [BGRAD_W:0]          bg_sum;

    assign s_ready  = (state_reg == ST_IDLE) && !clr_active_reg;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    assign rd_w  = wp_rdata[DATA_W-1:0];
    assign rd_b  = wp_rdata[WP_W-1:DATA_W];
    assign rd_wg = gr_rdata[WGRAD_W-1:0];
    assign rd_bg = gr_rdata[GR_W-1:WGRAD_W];

    // validity checks and address, from the finished divider
    always_comb begin
        cfg_ok = (cfg_cc_reg != '0) && (cfg_sg_reg != '0) && (cfg_ps_reg != '0)
              && (32'(cfg_cc_reg) <= 32'(MAX_CHANNELS))
              && (32'(cfg_ps_reg) <= 32'(MAX_PLANE))
              && (div_cc_reg.rem == '0)
              && (32'(div_cc_reg.quot) <= 32'(MAX_GROUPS));
        in_range   = ({1'b0, item_reg.channel} < cfg_cc_reg)
                  && ({1'b0, item_reg.position} < cfg_ps_reg);
        mode_known = (item_reg.mode <= MODE_READ);
        access_ok  = mode_known && cfg_ok && in_range;
        addr_full  = 32'(div_ch_reg.quot) * 32'(MAX_PLANE) + 32'(item_reg.position);
    end

    // arithmetic for the write-back cycle
    always_comb begin
        fwd_sum = {{2{prod_a_reg[31]}}, prod_a_reg};
        if (cfg_be_reg) begin
            fwd_sum = fwd_sum + {{6{rd_b[DATA_W-1]}}, rd_b, 12'd0};
        end
        bwd_sum = {{2{prod_a_reg[31]}}, prod_a_reg};

        wg_sum = {rd_wg[WGRAD_W-1], rd_wg} + {{17{prod_b_reg[31]}}, prod_b_reg};
        case (wg_sum[WGRAD_W:WGRAD_W-1])
            2'b01:   wg_new = {1'b0, {(WGRAD_W-1){1'b1}}};
            2'b10:   wg_new = {1'b1, {(WGRAD_W-1){1'b0}}};
            default: wg_new = wg_sum[WGRAD_W-1:0];
        endcase

        bg_sum = {rd_bg[BGRAD_W-1], rd_bg}
               + {{(BGRAD_W-DATA_W+1){item_reg.top_grad[DATA_W-1]}}, item_reg.top_grad};
        if (!cfg_be_reg) begin
            bg_new = rd_bg;
        end else begin
            case (bg_sum[BGRAD_W:BGRAD_W-1])
                2'b01:   bg_new = {1'b0, {(BGRAD_W-1){1'b1}}};
                2'b10:   bg_new = {1'b1, {(BGRAD_W-1){1'b0}}};
                default: bg_new = bg_sum[BGRAD_W-1:0];
            endcase
        end

        mul_op = (item_reg.mode == MODE_FWD) ? item_reg.data_value : item_reg.top_grad;
    end

    // memory write ports
    always_comb begin
        wp_we    = (state_reg == ST_WRITE)
                && ((item_reg.mode == MODE_LOAD_W) || (item_reg.mode == MODE_LOAD_B));
        wp_wdata = (item_reg.mode == MODE_LOAD_W) ? {rd_b, item_reg.data_value}
                                                  : {item_reg.data_value, rd_w};
        gr_we    = clr_active_reg || ((state_reg == ST_WRITE)
                && ((item_reg.mode == MODE_BWD) || (item_reg.mode == MODE_READ)));
        gr_waddr = clr_active_reg ? clr_addr_reg : addr_reg;
        if (clr_active_reg || (item_reg.mode == MODE_READ)) begin
            gr_wdata = '0;
        end else begin
            gr_wdata = {bg_new, wg_new};
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next   = ST_DIVIDE;
                    div_cnt_next = '0;
                end
            end
            ST_DIVIDE: begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                state_next = access_ok ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            cfg_cc_reg     <= CH_COUNT_W'(1);
            cfg_sg_reg     <= SHARE_W'(1);
            cfg_ps_reg     <= PLANE_SZ_W'(1);
            cfg_be_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT: cfg_cc_reg <= cfg_wdata[CH_COUNT_W-1:0];
                    CFG_SHARE_GROUP:   cfg_sg_reg <= cfg_wdata[SHARE_W-1:0];
                    CFG_PLANE_SIZE:    cfg_ps_reg <= cfg_wdata[PLANE_SZ_W-1:0];
                    CFG_BIAS_ENABLE:   cfg_be_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    item_reg        <= s_data;
                    div_ch_reg.quot <= {1'b0, s_data.channel};
                    div_ch_reg.rem  <= '0;
                    div_cc_reg.quot <= cfg_cc_reg;
                    div_cc_reg.rem  <= '0;
                end
            end
            ST_DIVIDE: begin
                div_ch_reg <= div_step(div_ch_reg, cfg_sg_reg);
                div_cc_reg <= div_step(div_cc_reg, cfg_sg_reg);
            end
            ST_ADDR: begin
                res_value_reg <= '0;
                wg_out_reg    <= '0;
                bg_out_reg    <= '0;
                if (!mode_known) begin
                    status_reg <= STATUS_OK;
                end else if (!cfg_ok) begin
                    status_reg <= STATUS_CONFIG;
                end else if (!in_range) begin
                    status_reg <= STATUS_RANGE;
                end else begin
                    status_reg <= STATUS_OK;
                end
                if (addr_full >= 32'(STORE_DEPTH)) begin
                    addr_reg <= '0;
                end else begin
                    addr_reg <= addr_full[ADDR_W-1:0];
                end
            end
            ST_MULT: begin
                prod_a_reg <= 32'(mul_op) * 32'(rd_w);
                prod_b_reg <= 32'(item_reg.top_grad) * 32'(item_reg.data_value);
            end
            ST_WRITE: begin
                case (item_reg.mode)
                    MODE_FWD:  res_value_reg <= round_sat(fwd_sum);
                    MODE_BWD:  res_value_reg <= round_sat(bwd_sum);
                    MODE_READ: begin
                        wg_out_reg <= rd_wg;
                        bg_out_reg <= rd_bg;
                    end
                    default: ;
                endcase
            end
            ST_DONE: begin
                if (out_load) begin
                    out_data_reg.result_value    <= res_value_reg;
                    out_data_reg.weight_grad_out <= wg_out_reg;
                    out_data_reg.bias_grad_out   <= bg_out_reg;
                    out_data_reg.status          <= status_reg;
                end
            end
            default: ;
        endcase
    end

    gssb_ram #(
        .WIDTH (WP_W),
        .DEPTH (STORE_DEPTH)
    ) u_wp_ram (
        .clk   (aclk),
        .we    (wp_we),
        .waddr (addr_reg),
        .wdata (wp_wdata),
        .raddr (addr_reg),
        .rdata (wp_rdata)
    );

    gssb_ram #(
        .WIDTH (GR_W),
        .DEPTH (STORE_DEPTH)
    ) u_gr_ram (
        .clk   (aclk),
        .we    (gr_we),
        .waddr (gr_waddr),
        .wdata (gr_wdata),
        .raddr (addr_reg),
        .rdata (gr_rdata)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("beat accepted during gradient clear");

    a_accept_starts_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_DIVIDE) && (div_cnt_reg == '0))
        else $error("accepted beat did not start the divider");

    a_write_after_mult: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> ($past(state_reg) == ST_MULT))
        else $error("write-back without a preceding multiply");

    a_error_zero_values: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != STATUS_OK)) |->
            ((m_data.result_value == '0) && (m_data.weight_grad_out == '0)
             && (m_data.bias_grad_out == '0)))
        else $error("error beat carries non-zero values");

endmodule

`default_nettype wire

@@ tb/sv/grouped_spatial_scale_bias_tb.sv @@
// Self-checking bench for grouped_spatial_scale_bias: a queue-fed beat driver, a result
// monitor, and an in-bench model of the weight, bias and gradient stores.
// Depends on gssb_pkg and the block's RTL.
`default_nettype none

module grouped_spatial_scale_bias_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gssb_pkg::*;

    localparam int     STORE_DEPTH = MAX_GROUPS_DEF * MAX_PLANE_DEF;
    localparam int     IDLE_LIMIT  = 50000;
    localparam longint WGRAD_HI    = (longint'(1) <<< 47) - 1;
    localparam longint WGRAD_LO    = -(longint'(1) <<< 47);
    localparam longint BGRAD_HI    = (longint'(1) <<< 31) - 1;
    localparam longint BGRAD_LO    = -(longint'(1) <<< 31);

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_CHANNEL_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    grouped_spatial_scale_bias dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // shape registers as the block holds them
    logic [8:0]  ch_cnt  = 9'd1;
    logic [8:0]  share   = 9'd1;
    logic [10:0] plane   = 11'd1;
    logic        bias_en = 1'b0;

    bit signed [15:0] weight_mem [STORE_DEPTH];
    bit signed [15:0] bias_mem   [STORE_DEPTH];
    bit signed [47:0] wgrad_mem  [STORE_DEPTH];
    bit signed [31:0] bgrad_mem  [STORE_DEPTH];
    bit               w_loaded   [STORE_DEPTH];
    bit               b_loaded   [STORE_DEPTH];

    in_item_t  stim_beats  [$];
    out_item_t results_due [$];
    out_item_t exp_r;
    int        beats_queued = 0;
    int        beats_taken  = 0;
    int        fail_count   = 0;
    int        idle_cycles  = 0;
    logic      in_fire      = 1'b0;
    int        burst_left   = 0;
    int        gap_left     = 0;
    bit [5:0]  stall_tick   = '0;
    bit [15:0] stall_mask   = 16'hffff;

    function automatic logic [1:0] beat_status(input in_item_t b);
        if (b.mode > MODE_READ) return STATUS_OK;
        if (ch_cnt == 0 || share == 0 || plane == 0 || ch_cnt > MAX_CHANNELS ||
            plane > MAX_PLANE_DEF || ch_cnt % share != 0 || ch_cnt / share > MAX_GROUPS_DEF)
            return STATUS_CONFIG;
        if (b.channel >= ch_cnt || b.position >= plane) return STATUS_RANGE;
        return STATUS_OK;
    endfunction

    function automatic int entry_addr(input logic [7:0] ch, input logic [9:0] pos);
        return (int'(ch) / int'(share)) * MAX_PLANE_DEF + int'(pos);
    endfunction

    function automatic longint clamp_ll(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [15:0] q824_round(input longint p);
        longint s;
        s = clamp_ll((p + 2048) >>> 12, -32768, 32767);
        return s[15:0];
    endfunction

    function automatic out_item_t scale_bias_predict(input in_item_t b);
        out_item_t r;
        int        a;
        longint    acc;
        r = '0;
        r.status = beat_status(b);
        if (b.mode > MODE_READ || r.status != STATUS_OK) return r;
        a = entry_addr(b.channel, b.position);
        case (b.mode)
            MODE_LOAD_W: weight_mem[a] = b.data_value;
            MODE_LOAD_B: bias_mem[a] = b.data_value;
            MODE_FWD: begin
                acc = longint'($signed(b.data_value)) * longint'(weight_mem[a]);
                if (bias_en) acc += longint'(bias_mem[a]) <<< 12;
                r.result_value = q824_round(acc);
            end
            MODE_BWD: begin
                acc = longint'(wgrad_mem[a]) +
                      longint'($signed(b.top_grad)) * longint'($signed(b.data_value));
                wgrad_mem[a] = 48'(clamp_ll(acc, WGRAD_LO, WGRAD_HI));
                if (bias_en) begin
                    acc = longint'(bgrad_mem[a]) + longint'($signed(b.top_grad));
                    bgrad_mem[a] = 32'(clamp_ll(acc, BGRAD_LO, BGRAD_HI));
                end
                r.result_value = q824_round(longint'($signed(b.top_grad)) *
                                            longint'(weight_mem[a]));
            end
            default: begin
                r.weight_grad_out = wgrad_mem[a];
                r.bias_grad_out   = bgrad_mem[a];
                wgrad_mem[a] = '0;
                bgrad_mem[a] = '0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] rand_q412();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_beat(input logic [2:0] md, input int ch, input int pos,
                              input logic [15:0] x, input logic [15:0] g);
        in_item_t b;
        in_item_t ld;
        int       a;
        b.mode       = md;
        b.channel    = ch[7:0];
        b.position   = pos[9:0];
        b.data_value = x;
        b.top_grad   = g;
        if (md <= MODE_READ && beat_status(b) == STATUS_OK) begin
            a = entry_addr(b.channel, b.position);
            // load both planes before a forward or backward beat reads this entry
            if ((md == MODE_FWD || md == MODE_BWD) && !(w_loaded[a] && b_loaded[a])) begin
                ld = b;
                ld.mode       = MODE_LOAD_W;
                ld.data_value = rand_q412();
                stim_beats.push_back(ld);
                ld.mode       = MODE_LOAD_B;
                ld.data_value = rand_q412();
                stim_beats.push_back(ld);
                beats_queued += 2;
                w_loaded[a] = 1'b1;
                b_loaded[a] = 1'b1;
            end
            if (md == MODE_LOAD_W) w_loaded[a] = 1'b1;
            if (md == MODE_LOAD_B) b_loaded[a] = 1'b1;
        end
        stim_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic drain_results();
        while (beats_taken != beats_queued || results_due.size() != 0) @(negedge aclk);
    endtask

    task automatic set_shape(input int cnt, input int shr, input int pl, input int ben);
        logic [CFG_INDEX_W-1:0] idx  [4];
        int                     vals [4];
        idx  = '{CFG_CHANNEL_COUNT, CFG_SHARE_GROUP, CFG_PLANE_SIZE, CFG_BIAS_ENABLE};
        vals = '{cnt, shr, pl, ben};
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i][CFG_DATA_W-1:0];
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        ch_cnt  = cnt[8:0];
        share   = shr[8:0];
        plane   = pl[10:0];
        bias_en = ben[0];
        @(posedge aclk);
    endtask

    // sender: bursts of beats with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (stim_beats.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= stim_beats.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall on a random mask that is picked anew each time stall_tick wraps
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_tick == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_mask = 16'hffff;
                    1: stall_mask = 16'($urandom_range(0, 65535));
                    2: stall_mask = 16'h00ff;
                    default: stall_mask = 16'h8001;
                endcase
            end
            m_ready <= stall_mask[stall_tick[3:0]];
            stall_tick++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
            idle_cycles = 0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                results_due.push_back(scale_bias_predict(s_data));
                beats_taken++;
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    fail_count++;
                end else begin
                    exp_r = results_due.pop_front();
                    if (m_data.result_value !== exp_r.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               exp_r.result_value, m_data.result_value);
                        fail_count++;
                    end
                    if (m_data.weight_grad_out !== exp_r.weight_grad_out) begin
                        $error("weight_grad_out: expected %0d, got %0d",
                               exp_r.weight_grad_out, m_data.weight_grad_out);
                        fail_count++;
                    end
                    if (m_data.bias_grad_out !== exp_r.bias_grad_out) begin
                        $error("bias_grad_out: expected %0d, got %0d",
                               exp_r.bias_grad_out, m_data.bias_grad_out);
                        fail_count++;
                    end
                    if (m_data.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_data.status);
                        fail_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int rand_start;
        int phase;
        int groups;
        int cnt;
        int shr;
        int pl;
        int ch;
        int pos;
        int n;
        logic [2:0] md;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // shape after reset: one channel, one pixel, no bias
        queue_beat(MODE_READ,   0, 0, 16'h0000, 16'h0000);
        queue_beat(MODE_LOAD_W, 0, 0, 16'h8000, 16'h0000);
        queue_beat(MODE_LOAD_B, 0, 0, 16'h7fff, 16'h0000);
        queue_beat(MODE_FWD,    0, 0, 16'h8000, 16'h0000);
        queue_beat(MODE_FWD,    0, 0, 16'h7fff, 16'h0000);
        queue_beat(MODE_BWD,    0, 0, 16'h8000, 16'h8000);
        queue_beat(MODE_READ,   0, 0, 16'h0000, 16'h0000);
        queue_beat(MODE_FWD,    1, 0, 16'h1234, 16'h0000);
        queue_beat(MODE_FWD,    0, 1, 16'h1234, 16'h0000);
        for (int m = 5; m < 8; m++) queue_beat(m[2:0], 255, 1023, rand_q412(), rand_q412());
        drain_results();

        set_shape(256, 16, 1024, 1);
        queue_beat(MODE_LOAD_W, 255, 1023, 16'h1000, 16'h0000);
        queue_beat(MODE_LOAD_B, 255, 1023, 16'hffff, 16'h0000);
        queue_beat(MODE_FWD,    255, 1023, 16'h7fff, 16'h0000);
        queue_beat(MODE_LOAD_W, 0, 0, 16'h0800, 16'h0000);
        queue_beat(MODE_LOAD_B, 0, 0, 16'h0000, 16'h0000);
        queue_beat(MODE_FWD,    0, 0, 16'h0001, 16'h0000);
        queue_beat(MODE_FWD,    0, 0, 16'hffff, 16'h0000);
        queue_beat(MODE_FWD,    0, 0, 16'hfffd, 16'h0000);
        queue_beat(MODE_BWD,    255, 1023, 16'h8000, 16'h7fff);
        queue_beat(MODE_BWD,    255, 1023, 16'h7fff, 16'h8000);
        queue_beat(MODE_READ,   240, 1023, 16'h0000, 16'h0000);
        queue_beat(MODE_READ,   255, 1023, 16'h0000, 16'h0000);
        drain_results();

        rand_start = beats_queued;
        phase = 0;
        while (beats_queued - rand_start < 900) begin
            if (phase % 3 == 2) begin
                case ((phase / 3) % 8)
                    0: set_shape(0, 1, 4, $urandom_range(0, 1));
                    1: set_shape(4, 0, 4, $urandom_range(0, 1));
                    2: set_shape(4, 2, 0, $urandom_range(0, 1));
                    3: set_shape(300, 300, 4, $urandom_range(0, 1));
                    4: set_shape(4, 1, 1500, $urandom_range(0, 1));
                    5: set_shape(6, 4, 4, $urandom_range(0, 1));
                    6: set_shape(34, 2, 4, $urandom_range(0, 1));
                    default: set_shape(511, 511, 2047, $urandom_range(0, 1));
                endcase
                repeat (8) queue_beat(3'($urandom_range(0, 7)), $urandom_range(0, 255),
                                      $urandom_range(0, 1023), rand_q412(), rand_q412());
            end else begin
                if (phase == 0) begin
                    set_shape(256, 256, 1024, 0);
                end else if (phase == 1) begin
                    set_shape(1, 1, 1, 1);
                end else begin
                    groups = $urandom_range(1, 16);
                    shr    = $urandom_range(1, 256 / groups);
                    cnt    = shr * groups;
                    pl     = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                                         : $urandom_range(1, 1024);
                    set_shape(cnt, shr, pl, $urandom_range(0, 1));
                end
                n = $urandom_range(20, 60);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 75) begin
                        ch  = $urandom_range(0, int'(ch_cnt) - 1);
                        pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(plane) - 1)
                            : $urandom_range(0, (plane < 4 ? int'(plane) : 4) - 1);
                        case ($urandom_range(0, 9))
                            0: md = MODE_LOAD_W;
                            1: md = MODE_LOAD_B;
                            2, 3, 4: md = MODE_FWD;
                            5, 6, 7: md = MODE_BWD;
                            default: md = MODE_READ;
                        endcase
                        queue_beat(md, ch, pos, rand_q412(), rand_q412());
                    end else begin
                        queue_beat(3'($urandom_range(0, 7)), $urandom_range(0, 255),
                                   $urandom_range(0, 1023), rand_q412(), rand_q412());
                    end
                end
            end
            drain_results();
            phase++;
        end

        drain_results();
        repeat (40) @(negedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
